// ----- rtl/core/segment_intersection_defines.svh -----
// Assertion macros of the segment intersection RTL
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, checked every clock outside reset
`define SEGI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// antecedent this cycle, consequent next cycle
`define SEGI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SEGI_ASSERT(lbl, clk, rst, prop, msg)
`define SEGI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/core/segi_pkg.sv -----
// Shared widths, types and helpers of the segment intersection block
`default_nettype none
package segi_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_BITS   = 32;

   // derived widths
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int DEN_W   = CROSS_W + 1;
   localparam int QUOT_W  = COORD_BITS + FRAC_BITS;
   localparam int NUM_W   = DIFF_W + CROSS_W + FRAC_BITS;
   localparam int EXT_W   = COORD_BITS + FRAC_BITS + 2;

   // queue between front and back (power of two)
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [CROSS_W-1:0]    cross_type;

   // classified word handed from front to back
   typedef struct packed {
      logic                  hit;
      logic                  point_valid;
      logic                  den_zero;
      logic [DEN_W-1:0]      den;
      logic [CROSS_W-1:0]    num;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [DIFF_W-1:0]     delta_x;
      logic [DIFF_W-1:0]     delta_y;
   } seg_entry_type;

   // closed bounding box test of p against box spanned by q and r
   function automatic logic in_box(coord_type px, coord_type py, coord_type qx,
                                   coord_type qy, coord_type rx, coord_type ry);
      coord_type lox, hix, loy, hiy;
      lox = (qx < rx) ? qx : rx;
      hix = (qx < rx) ? rx : qx;
      loy = (qy < ry) ? qy : ry;
      hiy = (qy < ry) ? ry : qy;
      return (px >= lox) && (px <= hix) && (py >= loy) && (py <= hiy);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/segi_if.sv -----
// Request and response channel interfaces of the segment intersection block
`default_nettype none
interface segi_req_if;
   import segi_pkg::*;
   logic      valid;
   logic      ready;
   coord_type a_start_x;
   coord_type a_start_y;
   coord_type a_end_x;
   coord_type a_end_y;
   coord_type b_start_x;
   coord_type b_start_y;
   coord_type b_end_x;
   coord_type b_end_y;

   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segi_rsp_if;
   import segi_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       hit;
   logic                       point_valid;
   logic signed [OUT_BITS-1:0] cross_x;
   logic signed [OUT_BITS-1:0] cross_y;

   modport source (output valid, hit, point_valid, cross_x, cross_y, input ready);
   modport sink   (input valid, hit, point_valid, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/segi_front.sv -----
// Front end: cross products, then collinear / straddle classification
`default_nettype none
module segi_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   segi_req_if.sink                    req_ch,
   input  wire logic                   full,
   output logic                        push,
   output segi_pkg::seg_entry_type     push_word
);
   import segi_pkg::*;

   function automatic diff_type sub(coord_type a, coord_type b);
      return DIFF_W'(a) - DIFF_W'(b);
   endfunction

   function automatic cross_type cross_prod(diff_type ux, diff_type uy, diff_type vx,
                                            diff_type vy);
      logic signed [PROD_W-1:0] p0, p1;
      p0 = ux * vy;
      p1 = uy * vx;
      return CROSS_W'(p0) - CROSS_W'(p1);
   endfunction

   function automatic logic same_side(cross_type a, cross_type b);
      return (a != '0) && (b != '0) && (a[CROSS_W-1] == b[CROSS_W-1]);
   endfunction

   // stage registers
   logic      valid_ff, valid_in;
   cross_type d1_ff, d1_in, d2_ff, d2_in;
   cross_type c31_ff, c31_in, c32_ff, c32_in;
   cross_type s3_ff, s3_in, s4_ff, s4_in;
   logic      box_ff, box_in;
   coord_type x1_ff, x1_in, y1_ff, y1_in;
   diff_type  ax_ff, ax_in, ay_ff, ay_in;

   logic advance;

   // products of the accepted word
   always_comb begin
      diff_type x31, y31, x41, y41, x32, y32, x42, y42, bx, by;
      x31 = sub(req_ch.b_start_x, req_ch.a_start_x);
      y31 = sub(req_ch.b_start_y, req_ch.a_start_y);
      x41 = sub(req_ch.b_end_x,   req_ch.a_start_x);
      y41 = sub(req_ch.b_end_y,   req_ch.a_start_y);
      x32 = sub(req_ch.b_start_x, req_ch.a_end_x);
      y32 = sub(req_ch.b_start_y, req_ch.a_end_y);
      x42 = sub(req_ch.b_end_x,   req_ch.a_end_x);
      y42 = sub(req_ch.b_end_y,   req_ch.a_end_y);
      bx  = sub(req_ch.b_start_x, req_ch.b_end_x);
      by  = sub(req_ch.b_start_y, req_ch.b_end_y);
      ax_in = sub(req_ch.a_end_x, req_ch.a_start_x);
      ay_in = sub(req_ch.a_end_y, req_ch.a_start_y);
      d1_in  = cross_prod(x31, y31, x41, y41);
      d2_in  = cross_prod(x42, y42, x32, y32);
      c31_in = cross_prod(bx, by, x31, y31);
      c32_in = cross_prod(bx, by, x32, y32);
      s3_in  = cross_prod(ax_in, ay_in, x31, y31);
      s4_in  = cross_prod(ax_in, ay_in, x41, y41);
      box_in = in_box(req_ch.a_start_x, req_ch.a_start_y, req_ch.b_start_x,
                      req_ch.b_start_y, req_ch.b_end_x, req_ch.b_end_y)
            || in_box(req_ch.a_end_x, req_ch.a_end_y, req_ch.b_start_x,
                      req_ch.b_start_y, req_ch.b_end_x, req_ch.b_end_y)
            || in_box(req_ch.b_start_x, req_ch.b_start_y, req_ch.a_start_x,
                      req_ch.a_start_y, req_ch.a_end_x, req_ch.a_end_y)
            || in_box(req_ch.b_end_x, req_ch.b_end_y, req_ch.a_start_x,
                      req_ch.a_start_y, req_ch.a_end_x, req_ch.a_end_y);
      x1_in = req_ch.a_start_x;
      y1_in = req_ch.a_start_y;
   end

   // handshake
   assign push         = valid_ff && !full;
   assign advance      = !valid_ff || !full;
   assign req_ch.ready = advance;
   assign valid_in     = req_ch.valid ? 1'b1 : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_ch.valid) begin
         d1_ff  <= d1_in;
         d2_ff  <= d2_in;
         c31_ff <= c31_in;
         c32_ff <= c32_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         box_ff <= box_in;
         x1_ff  <= x1_in;
         y1_ff  <= y1_in;
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
      end
   end

   // classification
   always_comb begin
      logic             collinear, miss;
      logic [DEN_W-1:0] sum;
      collinear = (c31_ff == '0) && (c32_ff == '0);
      miss      = same_side(s3_ff, s4_ff) || same_side(c31_ff, c32_ff);
      sum       = {d1_ff[CROSS_W-1], d1_ff} + {d2_ff[CROSS_W-1], d2_ff};
      push_word.hit         = collinear ? box_ff : !miss;
      push_word.point_valid = !collinear && !miss;
      push_word.den_zero    = (sum == '0);
      push_word.den         = sum[DEN_W-1] ? (~sum + 1'b1) : sum;
      push_word.num         = d1_ff[CROSS_W-1] ? (~d1_ff + 1'b1) : d1_ff;
      push_word.start_x     = x1_ff;
      push_word.start_y     = y1_ff;
      push_word.delta_x     = ax_ff;
      push_word.delta_y     = ay_ff;
   end

endmodule
`default_nettype wire

// ----- rtl/core/segi_fifo.sv -----
// Short queue between the front and back ends
`default_nettype none
`include "segment_intersection_defines.svh"
module segi_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire segi_pkg::seg_entry_type push_word,
   output logic                        full,
   input  wire logic                   pop,
   output segi_pkg::seg_entry_type     pop_word,
   output logic                        avail
);
   import segi_pkg::*;

   seg_entry_type        mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign avail    = (count_ff != '0);
   assign pop_word = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   `SEGI_ASSERT(a_count_bound, clock, reset, count_ff <= FIFO_CW'(FIFO_DEPTH), "fifo overfilled")
   `SEGI_ASSERT(a_pop_nonempty, clock, reset, !pop || count_ff != '0, "pop from empty fifo")
   `SEGI_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "fill count lost a push")

endmodule
`default_nettype wire

// ----- rtl/core/segi_back.sv -----
// Back end: scaled product, bit-per-stage division, point assembly
`default_nettype none
module segi_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   avail,
   input  wire segi_pkg::seg_entry_type pop_word,
   output logic                        pop,
   segi_rsp_if.source                  rsp_ch
);
   import segi_pkg::*;

   typedef struct packed {
      logic                  hit;
      logic                  point_valid;
      logic                  den_zero;
      logic [DEN_W-1:0]      den;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic                  neg_x;
      logic                  neg_y;
   } meta_type;

   logic                 en;
   logic                 v_ff   [QUOT_W+1];
   logic                 v_in   [QUOT_W+1];
   meta_type             meta_ff [QUOT_W+1];
   meta_type             meta_in [QUOT_W+1];
   logic [DEN_W-1:0]     remx_ff [QUOT_W+1];
   logic [DEN_W-1:0]     remx_in [QUOT_W+1];
   logic [DEN_W-1:0]     remy_ff [QUOT_W+1];
   logic [DEN_W-1:0]     remy_in [QUOT_W+1];
   logic [QUOT_W-1:0]    lowx_ff [QUOT_W+1];
   logic [QUOT_W-1:0]    lowx_in [QUOT_W+1];
   logic [QUOT_W-1:0]    lowy_ff [QUOT_W+1];
   logic [QUOT_W-1:0]    lowy_in [QUOT_W+1];
   logic [QUOT_W-1:0]    qx_ff   [QUOT_W+1];
   logic [QUOT_W-1:0]    qx_in   [QUOT_W+1];
   logic [QUOT_W-1:0]    qy_ff   [QUOT_W+1];
   logic [QUOT_W-1:0]    qy_in   [QUOT_W+1];

   logic                       out_valid_ff, out_valid_in;
   logic                       hit_ff, hit_in, pv_ff, pv_in;
   logic signed [OUT_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;

   assign en  = !out_valid_ff || rsp_ch.ready;
   assign pop = en && avail;

   // entry stage and the division stages
   always_comb begin
      logic [DIFF_W-1:0]         magx, magy;
      logic [DIFF_W+CROSS_W-1:0] px, py;
      logic [NUM_W-1:0]          nx, ny;
      logic [DEN_W:0]            tx, ty, dd;
      logic                      gx, gy;
      // entry: magnitude of delta times |d1|, scaled, split for division
      magx = pop_word.delta_x[DIFF_W-1] ? (~pop_word.delta_x + 1'b1) : pop_word.delta_x;
      magy = pop_word.delta_y[DIFF_W-1] ? (~pop_word.delta_y + 1'b1) : pop_word.delta_y;
      px   = magx * pop_word.num;
      py   = magy * pop_word.num;
      nx   = NUM_W'(px) << FRAC_BITS;
      ny   = NUM_W'(py) << FRAC_BITS;
      v_in[0]    = pop;
      remx_in[0] = nx[NUM_W-1:QUOT_W];
      remy_in[0] = ny[NUM_W-1:QUOT_W];
      lowx_in[0] = nx[QUOT_W-1:0];
      lowy_in[0] = ny[QUOT_W-1:0];
      qx_in[0]   = '0;
      qy_in[0]   = '0;
      meta_in[0].hit         = pop_word.hit;
      meta_in[0].point_valid = pop_word.point_valid;
      meta_in[0].den_zero    = pop_word.den_zero;
      meta_in[0].den         = pop_word.den;
      meta_in[0].start_x     = pop_word.start_x;
      meta_in[0].start_y     = pop_word.start_y;
      meta_in[0].neg_x       = pop_word.delta_x[DIFF_W-1];
      meta_in[0].neg_y       = pop_word.delta_y[DIFF_W-1];
      // one restoring division step per stage, both axes
      for (int k = 0; k < QUOT_W; k++) begin
         dd = {1'b0, meta_ff[k].den};
         tx = {remx_ff[k], lowx_ff[k][QUOT_W-1]};
         ty = {remy_ff[k], lowy_ff[k][QUOT_W-1]};
         gx = (tx >= dd);
         gy = (ty >= dd);
         remx_in[k+1] = gx ? DEN_W'(tx - dd) : DEN_W'(tx);
         remy_in[k+1] = gy ? DEN_W'(ty - dd) : DEN_W'(ty);
         lowx_in[k+1] = lowx_ff[k] << 1;
         lowy_in[k+1] = lowy_ff[k] << 1;
         qx_in[k+1]   = {qx_ff[k][QUOT_W-2:0], gx};
         qy_in[k+1]   = {qy_ff[k][QUOT_W-2:0], gy};
         meta_in[k+1] = meta_ff[k];
         v_in[k+1]    = v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUOT_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k <= QUOT_W; k++) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QUOT_W; k++) begin
            meta_ff[k] <= meta_in[k];
            remx_ff[k] <= remx_in[k];
            remy_ff[k] <= remy_in[k];
            lowx_ff[k] <= lowx_in[k];
            lowy_ff[k] <= lowy_in[k];
            qx_ff[k]   <= qx_in[k];
            qy_ff[k]   <= qy_in[k];
         end
      end
   end

   // point assembly: start scaled, plus or minus the offset, low bits kept
   always_comb begin
      meta_type                m;
      logic signed [EXT_W-1:0] bx, by, sx, sy;
      m  = meta_ff[QUOT_W];
      bx = EXT_W'($signed(m.start_x)) <<< FRAC_BITS;
      by = EXT_W'($signed(m.start_y)) <<< FRAC_BITS;
      sx = m.neg_x ? bx - $signed(EXT_W'(qx_ff[QUOT_W]))
                   : bx + $signed(EXT_W'(qx_ff[QUOT_W]));
      sy = m.neg_y ? by - $signed(EXT_W'(qy_ff[QUOT_W]))
                   : by + $signed(EXT_W'(qy_ff[QUOT_W]));
      if (m.den_zero) begin
         sx = bx;
         sy = by;
      end
      out_valid_in = v_ff[QUOT_W];
      hit_in       = m.hit;
      pv_in        = m.point_valid;
      cx_in        = m.point_valid ? OUT_BITS'(sx) : '0;
      cy_in        = m.point_valid ? OUT_BITS'(sy) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         pv_ff  <= pv_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.hit         = hit_ff;
   assign rsp_ch.point_valid = pv_ff;
   assign rsp_ch.cross_x     = cx_ff;
   assign rsp_ch.cross_y     = cy_ff;

endmodule
`default_nettype wire

// ----- rtl/core/segment_intersection.sv -----
// Word path: front stage, queue, entry stage, division stages, output register.
// Throughput: one word per cycle while rsp_ch is ready; one quotient bit per stage.
// Front (products, classification) and back (division) are decoupled by a 4-entry queue.
// Reset: synchronous, clears all valid flags and the queue; no clearing pass.
`default_nettype none
module segment_intersection (
   input  wire logic clock,
   input  wire logic reset,
   segi_req_if.sink  req_ch,
   segi_rsp_if.source rsp_ch
);
   import segi_pkg::*;

   logic          push, full, pop, avail;
   seg_entry_type push_word, pop_word;

   segi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .full      (full),
      .push      (push),
      .push_word (push_word)
   );

   segi_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .pop       (pop),
      .pop_word  (pop_word),
      .avail     (avail)
   );

   segi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .avail    (avail),
      .pop_word (pop_word),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
`default_nettype wire
